// File: src/gpma_pkg.sv
package gpma_pkg;

    localparam int GROUP_BITS = 4;
    localparam int MAX_GROUPS = 1 << GROUP_BITS;
    localparam int CELLS      = MAX_GROUPS * MAX_GROUPS;
    localparam int ADDR_W     = 2 * GROUP_BITS;
    localparam int DIST_W     = 16;
    localparam int SUM_W      = 36;
    localparam int CNT_W      = 20;
    localparam int MEAN_W     = 24;
    localparam int FRAC_BITS  = 8;
    localparam int QUO_W      = SUM_W + FRAC_BITS;
    localparam int DIV_STEPS  = QUO_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [DIST_W-1:0] distance;
        logic              dist_infinite;
        logic [GROUP_BITS-1:0] group_a;
        logic [GROUP_BITS-1:0] group_b;
    } t_in_item;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_value;
        logic [CNT_W-1:0]  pair_count;
        logic              cell_empty;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic wr_en;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic infinite;
        logic count_zero;
        logic out_busy;
    } t_sts;

endpackage

// File: src/grouped_pair_mean_accumulator_core.sv
// Grouped pair mean accumulator. Keeps a running sum (36 bits) and count
// (20 bits) of finite distances for every unordered pair of 16 groups, stored
// in a 256-entry single-port table addressed by {higher group, lower group}.
// An add transaction (opcode 0) fetches the cell and then writes back the
// saturated sum and count; infinite samples are dropped and produce no
// result. A read transaction (opcode 1) returns one result: count, mean as
// floor(sum*256/count) with 8 fraction bits saturated to 24 bits, and an
// empty flag when the count is zero (mean and count then read as zero). A
// read of a non-empty cell runs the bit-serial restoring divider, which
// produces one of 44 quotient bits per cycle; an empty cell skips the
// divider. A finished result waits in an output register, so the next
// transaction is accepted while it is still stalled downstream. Per-cell valid
// flops are cleared by reset, so the table needs no clearing pass and the
// block accepts input right after reset. The block orders each group pair
// itself; walking the matrix triangle and one-based label conversion are up
// to the host.
module grouped_pair_mean_accumulator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gpma_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gpma_pkg::t_out_item o_out_data
);
    import gpma_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: accept, fetch, divide, hand off
    gpma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // cell table, saturating update, divider and output register
    gpma_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted transaction holds off the next one in the following cycle
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    // a new result only ever comes from the sequencer's hand-off
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("result appeared without a hand-off");

    // never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("stalled result overwritten");

    // table write never coincides with divider load, divider step or hand-off
    a_wr_vs_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_en |-> !(w_cmd.div_load || w_cmd.div_step || w_cmd.out_load))
        else $error("write-back overlaps read work");

endmodule

// File: src/gpma_ctrl.sv
module gpma_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gpma_pkg::t_sts i_sts,
    output gpma_pkg::t_cmd o_cmd
);
    import gpma_pkg::*;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                if (i_sts.is_read) begin
                    o_cmd.div_load = 1'b1;
                    n_step         = '0;
                    n_state        = i_sts.count_zero ? S_DONE : S_DIV;
                end else begin
                    // skip infinite samples
                    o_cmd.wr_en = !i_sts.infinite;
                    n_state     = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: src/gpma_dpath.sv
module gpma_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gpma_pkg::t_in_item  i_in_data,
    input  gpma_pkg::t_cmd      i_cmd,
    output gpma_pkg::t_sts      o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output gpma_pkg::t_out_item o_out_data
);
    import gpma_pkg::*;

    logic [SUM_W+CNT_W-1:0] r_mem [CELLS];
    logic [CELLS-1:0]       r_valid;
    logic [SUM_W+CNT_W-1:0] r_rd_data;
    logic                   r_rd_vld;

    logic [ADDR_W-1:0]  r_addr;
    logic [DIST_W-1:0]  r_dist;
    logic               r_inf;
    logic               r_op;

    logic [CNT_W-1:0]   r_div_cnt;
    logic [CNT_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;

    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [GROUP_BITS-1:0] grp_hi, grp_lo;
    logic [ADDR_W-1:0]     in_addr;
    logic [SUM_W-1:0]      rd_sum, n_sum;
    logic [CNT_W-1:0]      rd_cnt, n_cnt;
    logic [SUM_W:0]        sum_ext;
    logic [CNT_W:0]        trial, diff;
    logic                  ge;
    logic [MEAN_W-1:0]     mean;

    // lower triangle: higher group is the row
    always_comb begin
        if (i_in_data.group_a > i_in_data.group_b) begin
            grp_hi = i_in_data.group_a;
            grp_lo = i_in_data.group_b;
        end else begin
            grp_hi = i_in_data.group_b;
            grp_lo = i_in_data.group_a;
        end
        in_addr = {grp_hi, grp_lo};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= r_mem[in_addr];
            r_addr    <= in_addr;
            r_dist    <= i_in_data.distance;
            r_inf     <= i_in_data.dist_infinite;
            r_op      <= i_in_data.opcode;
        end
        if (i_cmd.wr_en) begin
            r_mem[r_addr] <= {n_sum, n_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd_vld <= r_valid[in_addr];
            end
            if (i_cmd.wr_en) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    // a cell never written reads as zero
    always_comb begin
        rd_sum  = r_rd_vld ? r_rd_data[SUM_W+CNT_W-1:CNT_W] : '0;
        rd_cnt  = r_rd_vld ? r_rd_data[CNT_W-1:0] : '0;
        sum_ext = {1'b0, rd_sum} + (SUM_W+1)'(r_dist);
        n_sum   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        n_cnt   = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
    end

    // restoring divider, one quotient bit per step
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        diff  = trial - {1'b0, r_div_cnt};
        ge    = (trial >= {1'b0, r_div_cnt});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_cnt <= rd_cnt;
            r_rem     <= '0;
            r_quo     <= {rd_sum, {FRAC_BITS{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    always_comb begin
        if (r_div_cnt == '0) begin
            mean = '0;
        end else if (|r_quo[QUO_W-1:MEAN_W]) begin
            mean = MEAN_MAX;
        end else begin
            mean = r_quo[MEAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.mean_value <= mean;
            r_out_data.pair_count <= r_div_cnt;
            r_out_data.cell_empty <= (r_div_cnt == '0);
        end
    end

    always_comb begin
        o_sts.is_read    = (r_op == OP_READ);
        o_sts.infinite   = r_inf;
        o_sts.count_zero = (rd_cnt == '0);
        o_sts.out_busy   = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
